/* hw/rtl/tmprof_pkg.sv */
// Shared types and constants for the trapezoidal motion profile generator.
`timescale 1ns / 1ps
`default_nettype none

package tmprof_pkg;

  // Move phase reported with every setpoint
  typedef enum logic [1:0] {
    PH_ACC  = 2'd0,
    PH_CRU  = 2'd1,
    PH_DEC  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_VEL   = 2'd2;
  localparam logic [1:0] CFG_ACC   = 2'd3;

  // Reset value of speed and acceleration: 1.0 in Q15.16
  localparam logic [30:0] ONE_Q16 = 31'd65536;

endpackage

`default_nettype wire

/* hw/rtl/trapezoid_motion_profile_top.sv */
// Top level: trapezoidal motion profile setpoint generator with setup sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one elapsed-time word per cycle on the input stream and passes it through the
// capture, select, first-product, second-product, quadratic, distance and output-word
// registers to its setpoint word. The pipeline moves as one: while a finished word waits
// on m_tready, every stage holds and s_tready is low. After reset and after every
// configuration write, a setup sequencer works out the profile times and distances with
// a one-bit-per-cycle divider, a one-step-per-cycle square root and a shift-add
// multiplier; input is held off (s_tready low) until the sequencer is idle again.
module trapezoid_motion_profile_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] elapsed_time
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] angle_setpoint, [33:32] phase, [34] fault
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wr_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV_TA, ST_DIV_T1, ST_DIV_TRI, ST_SQRT, ST_MUL_A, ST_MUL_SA,
    ST_MUL_L, ST_FIN
  } seq_t;

  // Configuration registers
  logic [31:0] start_angle, end_angle;
  logic [30:0] cruise_velocity, accel_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle     <= '0;
      end_angle       <= '0;
      cruise_velocity <= tmprof_pkg::ONE_Q16;
      accel_rate      <= tmprof_pkg::ONE_Q16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tmprof_pkg::CFG_START: start_angle     <= cfg_wr_data;
        tmprof_pkg::CFG_END:   end_angle       <= cfg_wr_data;
        tmprof_pkg::CFG_VEL:   cruise_velocity <= cfg_wr_data[30:0];
        tmprof_pkg::CFG_ACC:   accel_rate      <= cfg_wr_data[30:0];
        default: ;
      endcase
    end
  end

  // Derived profile values
  seq_t        state;
  logic [31:0] move_len;
  logic        up, zero_move, flt, trap;
  logic [47:0] ta, t1, tdec;
  logic [48:0] tend;
  logic [63:0] sa, base1, lin_gap;
  logic [62:0] vk, vkp;

  // Sequencer datapath registers
  logic [63:0]  dq;
  logic [31:0]  rem;
  logic [30:0]  dvsr;
  logic [63:0]  sn, sr, sb;
  logic [111:0] mc, acc;
  logic [47:0]  mp;
  logic [6:0]   cnt;

  // Setup arithmetic
  logic signed [32:0] diff;
  logic [31:0]  prep_dist;
  logic [62:0]  prep_da;
  logic [61:0]  prep_vv;
  logic [31:0]  rem_sh, rem_n;
  logic         ge;
  logic [63:0]  dq_n;
  logic [63:0]  s_try, sn_n, sr_n;
  logic [111:0] acc_n;

  always_comb begin
    diff      = $signed({end_angle[31], end_angle}) - $signed({start_angle[31], start_angle});
    prep_dist = diff[32] ? 32'(-diff) : diff[31:0];
    prep_da   = 63'(prep_dist) * 63'(accel_rate);
    prep_vv   = 62'(cruise_velocity) * 62'(cruise_velocity);
    // restoring divide step
    rem_sh    = {rem[30:0], dq[63]};
    ge        = rem_sh >= {1'b0, dvsr};
    rem_n     = ge ? rem_sh - {1'b0, dvsr} : rem_sh;
    dq_n      = {dq[62:0], ge};
    // integer square root step
    s_try     = sr + sb;
    if (sn >= s_try) begin
      sn_n = sn - s_try;
      sr_n = (sr >> 1) + sb;
    end else begin
      sn_n = sn;
      sr_n = sr >> 1;
    end
    // shift-add multiply step
    acc_n     = acc + (mp[0] ? mc : 112'd0);
  end

  // Setup sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PREP;
    end else if (cfg_wr_en) begin
      state <= ST_PREP;
    end else begin
      case (state)
        ST_IDLE: ;
        ST_PREP: begin
          move_len  <= prep_dist;
          up        <= !diff[32] && (prep_dist != 32'd0);
          zero_move <= prep_dist == 32'd0;
          flt       <= (cruise_velocity == 31'd0) || (accel_rate == 31'd0);
          trap      <= prep_da > 63'(prep_vv);
          rem       <= '0;
          cnt       <= '0;
          dvsr      <= accel_rate;
          if ((prep_dist == 32'd0) || (cruise_velocity == 31'd0) || (accel_rate == 31'd0)) begin
            state <= ST_IDLE;
          end else if (prep_da > 63'(prep_vv)) begin
            dq    <= {17'd0, cruise_velocity, 16'd0};
            state <= ST_DIV_TA;
          end else begin
            dq    <= {prep_dist, 32'd0};
            state <= ST_DIV_TRI;
          end
        end
        ST_DIV_TA, ST_DIV_T1, ST_DIV_TRI: begin
          dq  <= dq_n;
          rem <= rem_n;
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            cnt <= '0;
            rem <= '0;
            if (state == ST_DIV_TA) begin
              ta    <= dq_n[47:0];
              dq    <= {16'd0, move_len, 16'd0};
              dvsr  <= cruise_velocity;
              state <= ST_DIV_T1;
            end else if (state == ST_DIV_T1) begin
              t1    <= dq_n[47:0];
              mc    <= {81'd0, accel_rate};
              mp    <= ta;
              acc   <= '0;
              state <= ST_MUL_A;
            end else begin
              sn    <= dq_n;
              sr    <= '0;
              sb    <= 64'd1 << 62;
              state <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          sn  <= sn_n;
          sr  <= sr_n;
          sb  <= sb >> 2;
          cnt <= cnt + 7'd1;
          if (cnt == 7'd31) begin
            cnt   <= '0;
            ta    <= {16'd0, sr_n[31:0]};
            t1    <= {16'd0, sr_n[31:0]};
            mc    <= {81'd0, accel_rate};
            mp    <= {16'd0, sr_n[31:0]};
            acc   <= '0;
            state <= ST_MUL_A;
          end
        end
        ST_MUL_A, ST_MUL_SA, ST_MUL_L: begin
          acc <= acc_n;
          mc  <= mc << 1;
          mp  <= mp >> 1;
          cnt <= cnt + 7'd1;
          if (cnt == 7'd47) begin
            cnt <= '0;
            if (state == ST_MUL_A) begin
              vkp   <= acc_n[62:0];
              mc    <= {49'd0, acc_n[62:0]};
              mp    <= ta;
              acc   <= '0;
              state <= ST_MUL_SA;
            end else if (state == ST_MUL_SA) begin
              sa <= acc_n[96:33];
              // cruise distance V*(t1-ta) only exists for a trapezoid
              if (trap) begin
                mc    <= {81'd0, cruise_velocity};
                mp    <= t1 - ta;
                acc   <= '0;
                state <= ST_MUL_L;
              end else begin
                state <= ST_FIN;
              end
            end else begin
              lin_gap <= acc_n[79:16];
              state   <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          base1 <= trap ? sa + lin_gap : sa;
          vk    <= trap ? {32'd0, cruise_velocity} : vkp;
          tdec  <= trap ? t1 : ta;
          tend  <= trap ? 49'(t1) + 49'(ta) : {ta, 1'b0};
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Pipeline control: all stages move when the output slot is free or taken
  logic       en;
  logic [5:0] vld;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && (state == ST_IDLE);

  // Stage registers
  logic [31:0] t_r;
  tmprof_pkg::phase_t ph2, ph3, ph4, ph5, ph6;
  logic [31:0] x2, y2, x3;
  logic [62:0] c2, ax3, cyh3, axh4;
  logic [63:0] cyl3, axl4;
  logic        k2, k3;
  logic [63:0] b2, b3, b4, b5, lin4, lin5, s6;
  logic [62:0] quad5;

  // Phase and operand selection
  tmprof_pkg::phase_t ph_c;
  logic [31:0] ycr, ydec;
  always_comb begin
    ycr  = t_r - ta[31:0];
    ydec = t_r - tdec[31:0];
    if ({16'd0, t_r} <= ta) ph_c = tmprof_pkg::PH_ACC;
    else if ({16'd0, t_r} <= tdec) ph_c = tmprof_pkg::PH_CRU;
    else if ({17'd0, t_r} <= tend) ph_c = tmprof_pkg::PH_DEC;
    else ph_c = tmprof_pkg::PH_DONE;
  end

  logic [95:0] lin_sum, quad_sum;
  logic [63:0] s_c;
  logic [31:0] sc;
  logic [32:0] sp;
  logic [31:0] ang;
  tmprof_pkg::phase_t ph_o;
  always_comb begin
    lin_sum  = {1'b0, cyh3, 32'd0} + {32'd0, cyl3};
    quad_sum = {1'b0, axh4, 32'd0} + {32'd0, axl4};
    s_c      = (ph5 == tmprof_pkg::PH_DEC) ? b5 + lin5 - {1'b0, quad5} : b5 + lin5 + {1'b0, quad5};
    sc       = (s6 > {32'd0, move_len}) ? move_len : s6[31:0];
    sp       = up ? {start_angle[31], start_angle} + {1'b0, sc}
                  : {start_angle[31], start_angle} - {1'b0, sc};
    ang      = sp[31:0];
    ph_o     = ph6;
    if (zero_move) begin
      ang  = end_angle;
      ph_o = tmprof_pkg::PH_DONE;
    end else if (flt) begin
      ang  = start_angle;
      ph_o = tmprof_pkg::PH_ACC;
    end else if (ph6 == tmprof_pkg::PH_DONE) begin
      ang  = end_angle;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[4:0], s_tvalid && s_tready};
      m_tvalid <= vld[5];
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= s_tdata;
      // select
      ph2  <= ph_c;
      x2   <= (ph_c == tmprof_pkg::PH_ACC) ? t_r
            : (ph_c == tmprof_pkg::PH_CRU) ? 32'd0 : ydec;
      y2   <= (ph_c == tmprof_pkg::PH_CRU) ? ycr : ydec;
      c2   <= (ph_c == tmprof_pkg::PH_ACC) ? 63'd0
            : (ph_c == tmprof_pkg::PH_CRU) ? {32'd0, cruise_velocity} : vk;
      k2   <= (ph_c == tmprof_pkg::PH_CRU) || trap;
      b2   <= (ph_c == tmprof_pkg::PH_ACC) ? 64'd0
            : (ph_c == tmprof_pkg::PH_CRU) ? sa : base1;
      // first products
      ph3  <= ph2;
      x3   <= x2;
      ax3  <= 63'(accel_rate) * 63'(x2);
      cyl3 <= 64'(c2[31:0]) * 64'(y2);
      cyh3 <= 63'(c2[62:32]) * 63'(y2);
      k3   <= k2;
      b3   <= b2;
      // second products, linear term
      ph4  <= ph3;
      axl4 <= 64'(ax3[31:0]) * 64'(x3);
      axh4 <= 63'(ax3[62:32]) * 63'(x3);
      lin4 <= k3 ? lin_sum[79:16] : lin_sum[95:32];
      b4   <= b3;
      // quadratic term
      ph5  <= ph4;
      quad5 <= quad_sum[95:33];
      lin5 <= lin4;
      b5   <= b4;
      // distance
      ph6  <= ph5;
      s6   <= s_c;
      // output word
      m_tdata <= {5'd0, flt && !zero_move, ph_o, ang};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tmprof_check.sv */
// Port-level checks for the motion profile generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tmprof_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        cfg_wr_en
);

  // A faulted move always reports the accelerate phase
  a_fault_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34] |-> m_tdata[33:32] == tmprof_pkg::PH_ACC)
    else $error("fault with nonzero phase");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed under stall");

  // Setup after a configuration write blocks input
  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> !s_tready)
    else $error("input accepted during setup");

  // Nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind trapezoid_motion_profile_top tmprof_check u_tmprof_check (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .cfg_wr_en(cfg_wr_en)
);

`default_nettype wire
